FILE: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue cells, top level and
// checker.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int IdW   = 16;
  localparam int PrioW = 16;

  // operation codes of an input item
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_LIST   = 2'd3;

  // status codes of a result item
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic                    valid;
    logic [IdW-1:0]          id;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_TAKE_RIGHT,
    CMD_REMOVE
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

endpackage

FILE: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and moves it left or right
// with its neighbours on insert, pop, remove and list rotation.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  spq_pkg::cell_cmd_t               cmd,
  input  logic [spq_pkg::IdW-1:0]          new_id,
  input  logic signed [spq_pkg::PrioW-1:0] new_prio,
  input  spq_pkg::entry_t                  left_ent,
  input  logic                             left_ge,
  input  spq_pkg::entry_t                  right_ent,
  input  logic                             seen_in,
  input  spq_pkg::entry_t                  found_in,
  output spq_pkg::entry_t                  ent,
  output logic                             ge,
  output logic                             seen_out,
  output spq_pkg::entry_t                  found_out
);
  import spq_pkg::*;

  logic                    valid;
  logic [IdW-1:0]          id;
  logic signed [PrioW-1:0] prio;
  entry_t                  ent_next;
  logic                    match;

  assign ent = '{valid: valid, id: id, prio: prio};

  // slot stays put while it holds equal or higher priority
  assign ge       = valid && (prio >= new_prio);
  assign match    = valid && (id == new_id);
  assign seen_out = seen_in || match;

  // first match along the chain carries its entry to the end
  always_comb begin
    if (seen_in) begin
      found_out = found_in;
    end else if (match) begin
      found_out = ent;
    end else begin
      found_out = '0;
    end
  end

  always_comb begin
    ent_next = ent;
    case (cmd)
      CMD_INSERT: begin
        if (!ge) begin
          if (left_ge) begin
            ent_next = '{valid: 1'b1, id: new_id, prio: new_prio};
          end else begin
            ent_next = left_ent;
          end
        end
      end
      CMD_TAKE_RIGHT: ent_next = right_ent;
      CMD_REMOVE: begin
        if (seen_out) begin
          ent_next = right_ent;
        end
      end
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ent_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    id   <= ent_next.id;
    prio <= ent_next.prio;
  end

endmodule

FILE: sv/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Insert, pop and remove update the cell chain on accept; the result item is
// registered and appears the cycle after the input item is accepted, so a new
// item can be taken every cycle while the output is not stalled.
// A list on a non-empty queue holds the input off while the chain rotates once
// through every cell, one result item per stored entry as cell 0 passes by,
// from the list state on; an output stall pauses the rotation while it lasts.
// Synchronous reset empties the queue by clearing the slot valid bits.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       op,
  input  logic [spq_pkg::IdW-1:0]          task_id,
  input  logic signed [spq_pkg::PrioW-1:0] priority_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [spq_pkg::IdW-1:0]          out_id,
  output logic signed [spq_pkg::PrioW-1:0] out_priority,
  output logic                             last
);
  import spq_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int RotW = $clog2(CAPACITY);

  state_t            state, state_next;
  cell_cmd_t         cmd;
  logic              wrap;
  logic [CntW-1:0]   count, count_next;
  logic [CntW-1:0]   emit_cnt;
  logic [RotW-1:0]   rot_cnt;

  entry_t            ent   [CAPACITY];
  logic              ge    [CAPACITY];
  logic              seen  [CAPACITY+1];
  entry_t            found [CAPACITY+1];
  entry_t            tail_in;

  logic              out_free, accept, empty, full;
  logic              load;
  logic [1:0]        load_status;
  entry_t            load_ent;
  logic              load_last;

  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;
  assign empty    = (count == '0);
  assign full     = (count == CntW'(CAPACITY));

  // list rotation feeds cell 0 back into the far end
  assign tail_in  = wrap ? ent[0] : '0;
  assign seen[0]  = 1'b0;
  assign found[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_ge;

    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign left_ge  = 1'b1;
    end else begin : g_body
      assign left_ent = ent[i-1];
      assign left_ge  = ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = tail_in;
    end else begin : g_mid
      assign right_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .new_id    (task_id),
      .new_prio  (priority_req),
      .left_ent  (left_ent),
      .left_ge   (left_ge),
      .right_ent (right_ent),
      .seen_in   (seen[i]),
      .found_in  (found[i]),
      .ent       (ent[i]),
      .ge        (ge[i]),
      .seen_out  (seen[i+1]),
      .found_out (found[i+1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && op == OP_LIST && !empty) begin
          state_next = ST_LIST;
        end
      end
      ST_LIST: begin
        if (out_free && rot_cnt == RotW'(CAPACITY - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall    = 1'b1;
    cmd         = CMD_HOLD;
    wrap        = 1'b0;
    load        = 1'b0;
    load_status = STATUS_OK;
    load_ent    = '0;
    load_last   = 1'b1;
    count_next  = count;
    unique case (state)
      ST_IDLE: begin
        in_stall = !out_free;
        if (accept) begin
          load = 1'b1;
          unique case (op)
            OP_INSERT: begin
              if (full) begin
                load_status = STATUS_FULL;
              end else begin
                cmd        = CMD_INSERT;
                count_next = count + CntW'(1);
              end
            end
            OP_POP: begin
              if (empty) begin
                load_status = STATUS_EMPTY;
              end else begin
                cmd        = CMD_TAKE_RIGHT;
                load_ent   = ent[0];
                count_next = count - CntW'(1);
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                load_status = STATUS_EMPTY;
              end else if (!seen[CAPACITY]) begin
                load_status = STATUS_NOT_FOUND;
              end else begin
                cmd        = CMD_REMOVE;
                load_ent   = found[CAPACITY];
                count_next = count - CntW'(1);
              end
            end
            OP_LIST: begin
              if (empty) begin
                load_status = STATUS_EMPTY;
              end else begin
                load = 1'b0;
              end
            end
            default: load = 1'b0;
          endcase
        end
      end
      ST_LIST: begin
        if (out_free) begin
          cmd       = CMD_TAKE_RIGHT;
          wrap      = 1'b1;
          load      = ent[0].valid;
          load_ent  = ent[0];
          load_last = ((emit_cnt + CntW'(1)) == count);
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      emit_cnt  <= '0;
      rot_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ST_LIST) begin
        if (out_free) begin
          rot_cnt <= rot_cnt + RotW'(1);
          if (ent[0].valid) begin
            emit_cnt <= emit_cnt + CntW'(1);
          end
        end
      end else begin
        rot_cnt  <= '0;
        emit_cnt <= '0;
      end
      if (out_free) begin
        out_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      status       <= load_status;
      out_id       <= load_ent.id;
      out_priority <= load_ent.prio;
      last         <= load_last;
    end
  end

endmodule

FILE: sv/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue result stream.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [1:0]                       op,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [1:0]                       status,
  input logic [spq_pkg::IdW-1:0]          out_id,
  input logic signed [spq_pkg::PrioW-1:0] out_priority,
  input logic                             last
);
  import spq_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_id)
      && $stable(out_priority) && $stable(last))
    else $error("stalled result item changed");

  // single-result operations answer in the next cycle
  a_single_next: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op != OP_LIST |=> out_valid && last)
    else $error("single-result item not answered next cycle");

  // error results close their item
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> last)
    else $error("error result without last");

  // error results carry no entry
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> out_id == '0 && out_priority == '0)
    else $error("error result carries an entry");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .op           (op),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .out_id       (out_id),
  .out_priority (out_priority),
  .last         (last)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted priority queue testbench
// Drives insert, pop, remove and list items at the block with random gaps
// and output stalls, both off in the steady stream test. Every accepted item
// is run through a behavioural copy of the sorted queue, and the replies it
// predicts are compared field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]         status;
    logic [15:0]        id;
    logic signed [15:0] prio;
    logic               last;
  } queue_reply_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [1:0]         op           = OP_INSERT;
  logic [15:0]        task_id      = '0;
  logic signed [15:0] priority_req = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [1:0]         status;
  logic [15:0]        out_id;
  logic signed [15:0] out_priority;
  logic               last;

  // behavioural copy of the queue contents
  logic [15:0]        held_id   [CAPACITY];
  logic signed [15:0] held_prio [CAPACITY];
  int                 held = 0;

  queue_reply_t pending_replies[$];
  queue_reply_t want;
  int           mismatches  = 0;
  int           cycle_count = 0;
  int           stall_left  = 0;
  bit           idle_on     = 1'b1;

  sorted_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .task_id      (task_id),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_id       (out_id),
    .out_priority (out_priority),
    .last         (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %h want %h", name, got, exp_val));
  endtask

  function automatic void push_reply(logic [1:0] st, logic [15:0] id,
                                     logic signed [15:0] prio, logic fin);
    queue_reply_t r;
    r.status = st;
    r.id     = id;
    r.prio   = prio;
    r.last   = fin;
    pending_replies.push_back(r);
  endfunction

  function automatic void drop_slot(int pos);
    int i;
    for (i = pos; i + 1 < held; i++) begin
      held_id[i]   = held_id[i + 1];
      held_prio[i] = held_prio[i + 1];
    end
    held--;
  endfunction

  function automatic void predict_queue_op(logic [1:0] kind, logic [15:0] id,
                                           logic signed [15:0] prio);
    int pos;
    int i;
    if (kind == OP_INSERT) begin
      if (held == CAPACITY) begin
        push_reply(STATUS_FULL, '0, '0, 1'b1);
      end else begin
        // new entry goes behind everything of equal or higher priority
        pos = 0;
        while (pos < held && held_prio[pos] >= prio) pos++;
        for (i = held; i > pos; i--) begin
          held_id[i]   = held_id[i - 1];
          held_prio[i] = held_prio[i - 1];
        end
        held_id[pos]   = id;
        held_prio[pos] = prio;
        held++;
        push_reply(STATUS_OK, '0, '0, 1'b1);
      end
    end else if (held == 0) begin
      push_reply(STATUS_EMPTY, '0, '0, 1'b1);
    end else if (kind == OP_POP) begin
      push_reply(STATUS_OK, held_id[0], held_prio[0], 1'b1);
      drop_slot(0);
    end else if (kind == OP_REMOVE) begin
      pos = 0;
      while (pos < held && held_id[pos] != id) pos++;
      if (pos == held) begin
        push_reply(STATUS_NOT_FOUND, '0, '0, 1'b1);
      end else begin
        push_reply(STATUS_OK, held_id[pos], held_prio[pos], 1'b1);
        drop_slot(pos);
      end
    end else begin
      for (i = 0; i < held; i++)
        push_reply(STATUS_OK, held_id[i], held_prio[i], i == held - 1);
    end
  endfunction

  // one item: optional gap, then hold the payload until accepted
  task automatic send_item(logic [1:0] kind, logic [15:0] id, logic signed [15:0] prio);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    task_id      <= id;
    priority_req <= prio;
    do @(posedge clk); while (in_stall);
    predict_queue_op(kind, id, prio);
  endtask

  function automatic logic [15:0] pick_id(int reuse_pct);
    if (held > 0 && $urandom_range(0, 99) < reuse_pct)
      return held_id[$urandom_range(0, held - 1)];
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [15:0] random_priority();
    int t;
    t = $urandom_range(0, 4);
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      // small spread so that ties are common
      2, 3: return 16'(t - 2);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = pending_replies.pop_front();
        compare_field("status", 16'(status), 16'(want.status));
        compare_field("out_id", out_id, want.id);
        compare_field("out_priority", out_priority, want.prio);
        compare_field("last", 16'(last), 16'(want.last));
      end
    end
  end

  task automatic test_empty_queue();
    send_item(OP_POP, 16'h0000, 16'h0000);
    send_item(OP_REMOVE, 16'h1234, 16'h0000);
    send_item(OP_LIST, 16'hffff, 16'hffff);
  endtask

  task automatic test_field_extremes();
    send_item(OP_INSERT, 16'h0000, 16'h8000);
    send_item(OP_INSERT, 16'hffff, 16'h7fff);
    send_item(OP_INSERT, 16'h0001, 16'h0000);
    send_item(OP_INSERT, 16'h8000, 16'hffff);
    send_item(OP_LIST, 16'h0000, 16'h0000);
    send_item(OP_POP, 16'h0000, 16'h0000);
    send_item(OP_REMOVE, 16'h5555, 16'h0000);
    // lowest priority sits in the last occupied slot
    send_item(OP_REMOVE, 16'h0000, 16'h0000);
  endtask

  task automatic test_ties_and_duplicates();
    send_item(OP_INSERT, 16'h0010, 16'sd5);
    send_item(OP_INSERT, 16'h0020, 16'sd5);
    send_item(OP_INSERT, 16'h0010, 16'sd5);
    send_item(OP_INSERT, 16'h0030, 16'sd7);
    send_item(OP_LIST, 16'h0000, 16'h0000);
    // only the first matching id in order goes
    send_item(OP_REMOVE, 16'h0010, 16'h0000);
    repeat (5) send_item(OP_POP, 16'h0000, 16'h0000);
  endtask

  task automatic test_full_queue();
    while (held < CAPACITY) send_item(OP_INSERT, pick_id(20), random_priority());
    repeat (2) send_item(OP_INSERT, pick_id(20), random_priority());
    send_item(OP_LIST, 16'h0000, 16'h0000);
    send_item(OP_REMOVE, held_id[CAPACITY - 1], 16'h0000);
    send_item(OP_INSERT, pick_id(20), random_priority());
    send_item(OP_LIST, 16'h0000, 16'h0000);
  endtask

  task automatic random_phase(int count, int insert_pct);
    int r;
    logic [1:0] kind;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
        kind = OP_INSERT;
      end else begin
        r = $urandom_range(0, 9);
        kind = r < 4 ? OP_POP : (r < 8 ? OP_REMOVE : OP_LIST);
      end
      send_item(kind, pick_id(kind == OP_REMOVE ? 75 : 20), random_priority());
    end
  endtask

  task automatic test_random_traffic();
    repeat (3) begin
      idle_on = $urandom_range(0, 3) != 0;
      random_phase(40, 85);
      idle_on = $urandom_range(0, 3) != 0;
      random_phase(30, 20);
      idle_on = $urandom_range(0, 3) != 0;
      random_phase(20, 50);
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    random_phase(20, 80);
    random_phase(20, 30);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_field_extremes();
    test_ties_and_duplicates();
    test_full_queue();
    test_random_traffic();
    test_steady_stream();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (CAPACITY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sorted_priority_queue.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
verif/testbench.sv
